// ----- sv/vces_pkg.sv -----
// ----------------------------------------------------------------------------
// vces_pkg: shared types and constants of the virtual cursor edge switch
// Request codes, message kinds, configuration and queue entry layouts.
// ----------------------------------------------------------------------------
package vces_pkg;

   localparam int DIM_W   = 15;
   localparam int COORD_W = 16;
   localparam int CUR_W   = 18;
   localparam int SEQ_W   = 32;
   localparam int LOC_W   = 14;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int DIV_W   = DIM_W + 1;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int CSR_W   = 3;

   localparam int ARM_ZONE_DEF  = 24;
   localparam int CMD_DEPTH_DEF = 2;
   localparam int RSP_DEPTH_DEF = 4;

   localparam logic [2:0] EDGE_NONE   = 3'd0;
   localparam logic [2:0] EDGE_LEFT   = 3'd1;
   localparam logic [2:0] EDGE_RIGHT  = 3'd2;
   localparam logic [2:0] EDGE_TOP    = 3'd3;
   localparam logic [2:0] EDGE_BOTTOM = 3'd4;

   localparam logic [CSR_W-1:0] CSR_RETURN_EDGE   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_REMOTE_WIDTH  = 3'd1;
   localparam logic [CSR_W-1:0] CSR_REMOTE_HEIGHT = 3'd2;
   localparam logic [CSR_W-1:0] CSR_LOCAL_WIDTH   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_LOCAL_HEIGHT  = 3'd4;
   localparam logic [CSR_W-1:0] CSR_RELATIVE      = 3'd5;
   localparam logic [CSR_W-1:0] CSR_AUTO_RETURN   = 3'd6;

   localparam logic [DIM_W-1:0] RST_REMOTE_WIDTH  = 15'd1080;
   localparam logic [DIM_W-1:0] RST_REMOTE_HEIGHT = 15'd2400;
   localparam logic [DIM_W-1:0] RST_LOCAL_WIDTH   = 15'd1920;
   localparam logic [DIM_W-1:0] RST_LOCAL_HEIGHT  = 15'd1080;

   typedef enum logic [1:0] {
      FUNC_MOVE   = 2'd0,
      FUNC_EDGE   = 2'd1,
      FUNC_TOGGLE = 2'd2,
      FUNC_LOST   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MSG_ENTER = 2'd0,
      MSG_LEAVE = 2'd1,
      MSG_ABS   = 2'd2,
      MSG_REL   = 2'd3
   } msg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_LEAVE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_PLACE
   } state_type;

   // dimensions already forced to at least one
   typedef struct packed {
      logic [2:0]       return_edge;
      logic [DIM_W-1:0] remote_width;
      logic [DIM_W-1:0] remote_height;
      logic [DIM_W-1:0] local_width;
      logic [DIM_W-1:0] local_height;
      logic             relative_mode;
      logic             auto_return;
   } cfg_type;

   typedef struct packed {
      func_type                  op;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      logic [LOC_W-1:0]          local_x;
      logic [LOC_W-1:0]          local_y;
   } cmd_type;

   typedef struct packed {
      msg_type                   kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SEQ_W-1:0]          count;
      logic                      on_remote;
      logic                      last;
   } rsp_type;

   function automatic logic [DIM_W-1:0] dim_fix(input logic [DIM_W-1:0] r);
      dim_fix = (r == '0) ? DIM_W'(1) : r;
   endfunction

endpackage

// ----- sv/vces_queue.sv -----
// ----------------------------------------------------------------------------
// vces_queue: small register queue
// First in, first out store with full, empty and fill count.
// ----------------------------------------------------------------------------
module vces_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [WIDTH-1:0]                 wdata,
   output logic                             full,
   input  logic                             pop,
   output logic [WIDTH-1:0]                 rdata,
   output logic                             empty,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign count   = fill_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- sv/vces_front.sv -----
// ----------------------------------------------------------------------------
// vces_front: request intake
// Accepts requests, drops those that need the link while it is down,
// and queues the rest as commands.
// ----------------------------------------------------------------------------
module vces_front (
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [1:0]                               req_func,
   input  logic signed [vces_pkg::COORD_W-1:0]      req_dx,
   input  logic signed [vces_pkg::COORD_W-1:0]      req_dy,
   input  logic [vces_pkg::LOC_W-1:0]               req_local_x,
   input  logic [vces_pkg::LOC_W-1:0]               req_local_y,
   input  logic                                     req_link_active,
   input  logic                                     cmd_full,
   output logic                                     cmd_push,
   output vces_pkg::cmd_type                        cmd
);

   vces_pkg::func_type func;
   logic               keep;

   assign func = vces_pkg::func_type'(req_func);

   always_comb begin
      unique case (func)
         vces_pkg::FUNC_MOVE:   keep = 1'b1;
         vces_pkg::FUNC_LOST:   keep = 1'b1;
         vces_pkg::FUNC_EDGE:   keep = req_link_active;
         vces_pkg::FUNC_TOGGLE: keep = req_link_active;
         default:               keep = 1'b0;
      endcase
   end

   assign req_full    = cmd_full;
   assign cmd_push    = req_push && !cmd_full && keep;
   assign cmd.op      = func;
   assign cmd.dx      = req_dx;
   assign cmd.dy      = req_dy;
   assign cmd.local_x = req_local_x;
   assign cmd.local_y = req_local_y;

endmodule

// ----- sv/vces_exec.sv -----
// ----------------------------------------------------------------------------
// vces_exec: cursor engine
// Holds the screen state and cursor, runs commands and writes messages.
// Proportional entry uses one multiply and a restoring divider.
// ----------------------------------------------------------------------------
module vces_exec #(
   parameter int ARM_ZONE = vces_pkg::ARM_ZONE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vces_pkg::cfg_type    cfg,
   input  logic                 cmd_valid,
   input  vces_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_room,
   output logic                 rsp_push,
   output vces_pkg::rsp_type    rsp
);

   localparam int CW = vces_pkg::CUR_W;
   localparam int DW = vces_pkg::DIM_W;
   localparam logic signed [CW-1:0] ARM_THR = CW'(ARM_ZONE);

   vces_pkg::state_type          state_ff, state_in;
   logic                         on_remote_ff, on_remote_in;
   logic                         armed_ff, armed_in;
   logic signed [CW-1:0]         cur_x_ff, cur_x_in;
   logic signed [CW-1:0]         cur_y_ff, cur_y_in;
   logic [vces_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   vces_pkg::cmd_type            cmd_ff, cmd_in;
   logic [vces_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [vces_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [vces_pkg::DIV_W-1:0]   rem_ff, rem_in;
   logic [vces_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   logic signed [CW-1:0]         sx, sy, wm1, hm1, inward, cx_c, cy_c;
   logic signed [CW-1:0]         ctr_x, ctr_y;
   logic                         edge_ok, edge_entry, along_y, crossed, armed_new;
   logic [DW-1:0]                sel_p_dim, sel_l_dim, lim;
   logic [vces_pkg::LOC_W-1:0]   sel_p;
   logic [DW-1:0]                pos;
   logic [vces_pkg::DIV_W:0]     trial;
   logic                         take;

   assign wm1   = $signed({3'b000, cfg.remote_width}) - 18'sd1;
   assign hm1   = $signed({3'b000, cfg.remote_height}) - 18'sd1;
   assign ctr_x = $signed({4'b0000, cfg.remote_width[DW-1:1]});
   assign ctr_y = $signed({4'b0000, cfg.remote_height[DW-1:1]});
   assign sx    = cur_x_ff + {{2{cmd_ff.dx[15]}}, cmd_ff.dx};
   assign sy    = cur_y_ff + {{2{cmd_ff.dy[15]}}, cmd_ff.dy};

   assign edge_entry = (cfg.return_edge == vces_pkg::EDGE_LEFT)
                    || (cfg.return_edge == vces_pkg::EDGE_RIGHT)
                    || (cfg.return_edge == vces_pkg::EDGE_TOP)
                    || (cfg.return_edge == vces_pkg::EDGE_BOTTOM);
   assign edge_ok    = cfg.auto_return && edge_entry;
   assign along_y    = (cfg.return_edge == vces_pkg::EDGE_LEFT)
                    || (cfg.return_edge == vces_pkg::EDGE_RIGHT);

   always_comb begin
      if (cfg.return_edge == vces_pkg::EDGE_LEFT) begin
         inward = sx;
      end else if (cfg.return_edge == vces_pkg::EDGE_RIGHT) begin
         inward = wm1 - sx;
      end else if (cfg.return_edge == vces_pkg::EDGE_TOP) begin
         inward = sy;
      end else begin
         inward = hm1 - sy;
      end
   end

   assign crossed   = inward[CW-1];
   assign armed_new = armed_ff || (inward >= ARM_THR);

   assign cx_c = sx[CW-1] ? '0 : ((sx > wm1) ? wm1 : sx);
   assign cy_c = sy[CW-1] ? '0 : ((sy > hm1) ? hm1 : sy);

   // entry along the return edge
   assign sel_p     = along_y ? cmd_ff.local_y : cmd_ff.local_x;
   assign sel_p_dim = along_y ? cfg.remote_height : cfg.remote_width;
   assign sel_l_dim = along_y ? cfg.local_height : cfg.local_width;
   assign lim       = sel_p_dim - DW'(1);
   assign pos       = (num_ff > vces_pkg::NUM_W'(lim)) ? lim : num_ff[DW-1:0];

   assign trial = {rem_ff, num_ff[vces_pkg::NUM_W-1]};
   assign take  = (trial >= {1'b0, sel_l_dim, 1'b0});

   always_comb begin
      state_in     = state_ff;
      on_remote_in = on_remote_ff;
      armed_in     = armed_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      seq_in       = seq_ff;
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp          = '0;

      unique case (state_ff)
         vces_pkg::ST_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = vces_pkg::ST_RUN;
            end
         end

         vces_pkg::ST_RUN: begin
            state_in = vces_pkg::ST_IDLE;
            unique case (cmd_ff.op)
               vces_pkg::FUNC_MOVE: begin
                  if (on_remote_ff) begin
                     if (edge_ok) begin
                        armed_in = armed_new;
                     end
                     if (edge_ok && crossed && armed_new) begin
                        on_remote_in = 1'b0;
                        rsp_push     = 1'b1;
                        if (cfg.relative_mode) begin
                           rsp.kind      = vces_pkg::MSG_REL;
                           rsp.x         = cmd_ff.dx;
                           rsp.y         = cmd_ff.dy;
                           rsp.on_remote = 1'b1;
                           state_in      = vces_pkg::ST_LEAVE;
                        end else begin
                           rsp.kind = vces_pkg::MSG_LEAVE;
                           rsp.last = 1'b1;
                        end
                     end else begin
                        cur_x_in      = cx_c;
                        cur_y_in      = cy_c;
                        rsp_push      = 1'b1;
                        rsp.on_remote = 1'b1;
                        rsp.last      = 1'b1;
                        if (cfg.relative_mode) begin
                           rsp.kind = vces_pkg::MSG_REL;
                           rsp.x    = cmd_ff.dx;
                           rsp.y    = cmd_ff.dy;
                        end else begin
                           rsp.kind = vces_pkg::MSG_ABS;
                           rsp.x    = cx_c[15:0];
                           rsp.y    = cy_c[15:0];
                        end
                     end
                  end
               end

               vces_pkg::FUNC_EDGE, vces_pkg::FUNC_TOGGLE: begin
                  if (on_remote_ff) begin
                     if (cmd_ff.op == vces_pkg::FUNC_TOGGLE) begin
                        on_remote_in = 1'b0;
                        rsp_push     = 1'b1;
                        rsp.kind     = vces_pkg::MSG_LEAVE;
                        rsp.last     = 1'b1;
                     end
                  end else begin
                     seq_in       = seq_ff + vces_pkg::SEQ_W'(1);
                     on_remote_in = 1'b1;
                     armed_in     = 1'b0;
                     if ((cmd_ff.op == vces_pkg::FUNC_EDGE) && edge_entry) begin
                        state_in = vces_pkg::ST_MUL;
                     end else begin
                        cur_x_in      = ctr_x;
                        cur_y_in      = ctr_y;
                        rsp_push      = 1'b1;
                        rsp.kind      = vces_pkg::MSG_ENTER;
                        rsp.x         = ctr_x[15:0];
                        rsp.y         = ctr_y[15:0];
                        rsp.count     = seq_ff + vces_pkg::SEQ_W'(1);
                        rsp.on_remote = 1'b1;
                        rsp.last      = 1'b1;
                     end
                  end
               end

               vces_pkg::FUNC_LOST: begin
                  on_remote_in = 1'b0;
               end

               default: begin
                  state_in = vces_pkg::ST_IDLE;
               end
            endcase
         end

         vces_pkg::ST_LEAVE: begin
            rsp_push = 1'b1;
            rsp.kind = vces_pkg::MSG_LEAVE;
            rsp.last = 1'b1;
            state_in = vces_pkg::ST_IDLE;
         end

         vces_pkg::ST_MUL: begin
            prod_in  = vces_pkg::PROD_W'(sel_p_dim) * vces_pkg::PROD_W'({sel_p, 1'b1});
            state_in = vces_pkg::ST_LOAD;
         end

         vces_pkg::ST_LOAD: begin
            num_in   = vces_pkg::NUM_W'(prod_ff) + vces_pkg::NUM_W'(sel_l_dim);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = vces_pkg::ST_DIV;
         end

         vces_pkg::ST_DIV: begin
            rem_in = take ? vces_pkg::DIV_W'(trial - {1'b0, sel_l_dim, 1'b0})
                          : trial[vces_pkg::DIV_W-1:0];
            num_in = {num_ff[vces_pkg::NUM_W-2:0], take};
            cnt_in = cnt_ff + vces_pkg::CNT_W'(1);
            if (cnt_ff == vces_pkg::CNT_W'(vces_pkg::NUM_W - 1)) begin
               state_in = vces_pkg::ST_PLACE;
            end
         end

         vces_pkg::ST_PLACE: begin
            if (cfg.return_edge == vces_pkg::EDGE_LEFT) begin
               cur_x_in = '0;
               cur_y_in = $signed({3'b000, pos});
            end else if (cfg.return_edge == vces_pkg::EDGE_RIGHT) begin
               cur_x_in = wm1;
               cur_y_in = $signed({3'b000, pos});
            end else if (cfg.return_edge == vces_pkg::EDGE_TOP) begin
               cur_x_in = $signed({3'b000, pos});
               cur_y_in = '0;
            end else begin
               cur_x_in = $signed({3'b000, pos});
               cur_y_in = hm1;
            end
            rsp_push      = 1'b1;
            rsp.kind      = vces_pkg::MSG_ENTER;
            rsp.x         = cur_x_in[15:0];
            rsp.y         = cur_y_in[15:0];
            rsp.count     = seq_ff;
            rsp.on_remote = 1'b1;
            rsp.last      = 1'b1;
            state_in      = vces_pkg::ST_IDLE;
         end

         default: begin
            state_in = vces_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vces_pkg::ST_IDLE;
         on_remote_ff <= 1'b0;
         armed_ff     <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         seq_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         on_remote_ff <= on_remote_in;
         armed_ff     <= armed_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ----- sv/virtual_cursor_edge_switch.sv -----
// ----------------------------------------------------------------------------
// virtual_cursor_edge_switch: virtual cursor for a remote screen
// Configuration registers, request queue, cursor engine and message queue.
//
//   channel   handshake          payload
//   req_      push / full        func, dx, dy, local_x, local_y, link_active
//   rsp_      empty / pop        msg_kind, out_x, out_y, enter_count,
//                                on_remote_now, last
//   csr_      wr_en              index, wdata
//
// A mouse delta, hotkey, link loss or centre entry runs the engine's idle and
// run states, a relative move followed by a leave also its leave state. An
// entry from the return edge runs one multiply, then a restoring divider at
// one quotient bit per cycle over 31 bits, then places the cursor. Reset is
// synchronous and clears both queues. The engine starts a request only when
// two message slots are free, so a stalled rsp_ side backs up into req_full.
// ----------------------------------------------------------------------------
module virtual_cursor_edge_switch #(
   parameter int ARM_ZONE  = vces_pkg::ARM_ZONE_DEF,
   parameter int CMD_DEPTH = vces_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = vces_pkg::RSP_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [1:0]                             req_func,
   input  logic signed [vces_pkg::COORD_W-1:0]    req_dx,
   input  logic signed [vces_pkg::COORD_W-1:0]    req_dy,
   input  logic [vces_pkg::LOC_W-1:0]             req_local_x,
   input  logic [vces_pkg::LOC_W-1:0]             req_local_y,
   input  logic                                   req_link_active,

   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [1:0]                             rsp_msg_kind,
   output logic signed [vces_pkg::COORD_W-1:0]    rsp_out_x,
   output logic signed [vces_pkg::COORD_W-1:0]    rsp_out_y,
   output logic [vces_pkg::SEQ_W-1:0]             rsp_enter_count,
   output logic                                   rsp_on_remote_now,
   output logic                                   rsp_last,

   input  logic                                   csr_wr_en,
   input  logic [vces_pkg::CSR_W-1:0]             csr_index,
   input  logic [vces_pkg::DIM_W-1:0]             csr_wdata
);

   localparam int CMD_BITS = $bits(vces_pkg::cmd_type);
   localparam int RSP_BITS = $bits(vces_pkg::rsp_type);
   localparam int RSP_FILL_W = $clog2(RSP_DEPTH + 1);

   logic [2:0]                 edge_ff, edge_in;
   logic [vces_pkg::DIM_W-1:0] rw_ff, rw_in, rh_ff, rh_in, lw_ff, lw_in, lh_ff, lh_in;
   logic                       rel_ff, rel_in, auto_ff, auto_in;
   vces_pkg::cfg_type          cfg;

   vces_pkg::cmd_type          cmd_wr, cmd_rd;
   logic [CMD_BITS-1:0]        cmd_rd_bits;
   logic                       cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

   vces_pkg::rsp_type          rsp_wr, rsp_rd;
   logic [RSP_BITS-1:0]        rsp_rd_bits;
   logic                       rsp_push, rsp_full, rsp_room;
   logic [RSP_FILL_W-1:0]      rsp_count;

   always_comb begin
      edge_in = edge_ff;
      rw_in   = rw_ff;
      rh_in   = rh_ff;
      lw_in   = lw_ff;
      lh_in   = lh_ff;
      rel_in  = rel_ff;
      auto_in = auto_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            vces_pkg::CSR_RETURN_EDGE:   edge_in = csr_wdata[2:0];
            vces_pkg::CSR_REMOTE_WIDTH:  rw_in   = csr_wdata;
            vces_pkg::CSR_REMOTE_HEIGHT: rh_in   = csr_wdata;
            vces_pkg::CSR_LOCAL_WIDTH:   lw_in   = csr_wdata;
            vces_pkg::CSR_LOCAL_HEIGHT:  lh_in   = csr_wdata;
            vces_pkg::CSR_RELATIVE:      rel_in  = csr_wdata[0];
            vces_pkg::CSR_AUTO_RETURN:   auto_in = csr_wdata[0];
            default:                     edge_in = edge_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= vces_pkg::EDGE_NONE;
         rw_ff   <= vces_pkg::RST_REMOTE_WIDTH;
         rh_ff   <= vces_pkg::RST_REMOTE_HEIGHT;
         lw_ff   <= vces_pkg::RST_LOCAL_WIDTH;
         lh_ff   <= vces_pkg::RST_LOCAL_HEIGHT;
         rel_ff  <= 1'b0;
         auto_ff <= 1'b1;
      end else begin
         edge_ff <= edge_in;
         rw_ff   <= rw_in;
         rh_ff   <= rh_in;
         lw_ff   <= lw_in;
         lh_ff   <= lh_in;
         rel_ff  <= rel_in;
         auto_ff <= auto_in;
      end
   end

   assign cfg.return_edge   = edge_ff;
   assign cfg.remote_width  = vces_pkg::dim_fix(rw_ff);
   assign cfg.remote_height = vces_pkg::dim_fix(rh_ff);
   assign cfg.local_width   = vces_pkg::dim_fix(lw_ff);
   assign cfg.local_height  = vces_pkg::dim_fix(lh_ff);
   assign cfg.relative_mode = rel_ff;
   assign cfg.auto_return   = auto_ff;

   vces_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_dx          (req_dx),
      .req_dy          (req_dy),
      .req_local_x     (req_local_x),
      .req_local_y     (req_local_y),
      .req_link_active (req_link_active),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd_wr)
   );

   vces_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd_bits),
      .empty (cmd_empty),
      .count (cmd_count)
   );

   assign cmd_rd   = vces_pkg::cmd_type'(cmd_rd_bits);
   assign rsp_room = !rsp_full && (rsp_count <= RSP_FILL_W'(RSP_DEPTH - 2))
                  && (cmd_count != '0);

   vces_exec #(
      .ARM_ZONE (ARM_ZONE)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   vces_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rd_bits),
      .empty (rsp_empty),
      .count (rsp_count)
   );

   assign rsp_rd            = vces_pkg::rsp_type'(rsp_rd_bits);
   assign rsp_msg_kind      = rsp_rd.kind;
   assign rsp_out_x         = rsp_rd.x;
   assign rsp_out_y         = rsp_rd.y;
   assign rsp_enter_count   = rsp_rd.count;
   assign rsp_on_remote_now = rsp_rd.on_remote;
   assign rsp_last          = rsp_rd.last;

endmodule
